// ===== design/qvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvt_pkg
// Shared constants, types and controller/datapath interface structs for the
// value table with greedy action select.
// ----------------------------------------------------------------------------
package qvt_pkg;

	// table geometry
	localparam int NUM_STATES  = 256;
	localparam int NUM_ACTIONS = 16;
	localparam int STORE_DEPTH = NUM_STATES * NUM_ACTIONS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// field widths
	localparam int VAL_W   = 32;
	localparam int STATE_W = 8;
	localparam int ACT_W   = 4;
	localparam int CNT_W   = 5;
	localparam int FULL_W  = STATE_W + CNT_W;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [CNT_W-1:0] ACTIONS_RESET = CNT_W'(NUM_ACTIONS);

	// item modes
	typedef enum logic [1:0] {
		MODE_READ   = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_ARGMAX = 2'd2,
		MODE_ARGMIN = 2'd3
	} mode_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear_en;
		logic write_en;
		logic issue_first;
		logic issue_visit;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic visit_last;
		logic is_write;
		logic is_read;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== design/qvt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/qvt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvt_ctrl
// Sequencer: clearing pass after reset, then per-item read, write or row scan.
// ----------------------------------------------------------------------------
module qvt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  qvt_pkg::ctrl_sts_t sts,
	output qvt_pkg::ctrl_cmd_t cmd
);
	import qvt_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.capture = item_valid;
				if (item_valid) begin
					state_nxt = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (sts.is_write) begin
					cmd.write_en = 1'b1;
					state_nxt    = ST_IDLE;
				end else begin
					cmd.issue_first = 1'b1;
					state_nxt       = sts.is_read ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue_visit = 1'b1;
				if (sts.visit_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// items are taken only between transactions
	assign item_stall = (state_q != ST_IDLE);

endmodule

// ===== design/qvt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvt_dp
// Datapath: item registers, address generation, table RAM, best-candidate
// compare stage and result register.
// ----------------------------------------------------------------------------
module qvt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  qvt_pkg::ctrl_cmd_t              cmd,
	output qvt_pkg::ctrl_sts_t              sts,
	input  logic [qvt_pkg::CNT_W-1:0]       actions_in_use,
	input  logic [1:0]                      mode,
	input  logic [qvt_pkg::STATE_W-1:0]     state_index,
	input  logic [qvt_pkg::ACT_W-1:0]       action_index,
	input  logic [qvt_pkg::ACT_W-1:0]       start_action,
	input  logic signed [qvt_pkg::VAL_W-1:0] write_value,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic signed [qvt_pkg::VAL_W-1:0] value_out,
	output logic [qvt_pkg::ACT_W-1:0]       chosen_action
);
	import qvt_pkg::*;

	logic [CNT_W-1:0]        n_eff;
	mode_t                   mode_q;
	logic [FULL_W-1:0]       base_q;
	logic [ACT_W-1:0]        act_q;
	logic [ACT_W-1:0]        start_q;
	logic signed [VAL_W-1:0] wv_q;
	logic [ADDR_W-1:0]       clr_cnt_q;
	logic [ACT_W-1:0]        visit_q;
	logic [ACT_W-1:0]        start_sel;
	logic [ACT_W-1:0]        rd_idx;
	logic [FULL_W-1:0]       full_addr;
	logic                    in_range;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [VAL_W-1:0]        ram_wdata;
	logic                    ram_re;
	logic [VAL_W-1:0]        ram_rdata;
	logic                    tag_valid_s1;
	logic                    tag_first_s1;
	logic                    tag_oor_s1;
	logic [ACT_W-1:0]        tag_idx_s1;
	logic signed [VAL_W-1:0] rd_val;
	logic                    take;
	logic [ACT_W-1:0]        best_idx_q;
	logic signed [VAL_W-1:0] best_val_q;
	logic                    result_valid_q;
	logic signed [VAL_W-1:0] value_out_q;
	logic [ACT_W-1:0]        chosen_q;

	// effective row length, clamped to one..NUM_ACTIONS
	always_comb begin
		if (actions_in_use == '0) begin
			n_eff = CNT_W'(1);
		end else if (actions_in_use > CNT_W'(NUM_ACTIONS)) begin
			n_eff = CNT_W'(NUM_ACTIONS);
		end else begin
			n_eff = actions_in_use;
		end
	end

	// item capture, row base computed on the way in
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode_t'(mode);
			base_q  <= FULL_W'(state_index) * FULL_W'(n_eff);
			act_q   <= action_index;
			start_q <= start_action;
			wv_q    <= write_value;
		end
	end

	// clearing and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			visit_q   <= '0;
		end else begin
			if (cmd.clear_en) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.issue_first) begin
				visit_q <= '0;
			end else if (cmd.issue_visit) begin
				visit_q <= visit_q + 1'b1;
			end
		end
	end

	// address generation
	assign start_sel = (CNT_W'(start_q) < n_eff) ? start_q : '0;
	always_comb begin
		if (cmd.issue_first) begin
			rd_idx = (mode_q == MODE_READ) ? act_q : start_sel;
		end else if (cmd.issue_visit) begin
			rd_idx = visit_q;
		end else begin
			rd_idx = act_q;
		end
	end
	assign full_addr = base_q + FULL_W'(rd_idx);
	assign in_range  = (full_addr < FULL_W'(STORE_DEPTH));

	// ram port muxing
	assign ram_we    = cmd.clear_en | (cmd.write_en & in_range);
	assign ram_waddr = cmd.clear_en ? clr_cnt_q : full_addr[ADDR_W-1:0];
	assign ram_wdata = cmd.clear_en ? '0 : VAL_W'(wv_q);
	assign ram_re    = cmd.issue_first | cmd.issue_visit;

	qvt_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (full_addr[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// tag travels alongside the ram read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_valid_s1 <= 1'b0;
		end else begin
			tag_valid_s1 <= ram_re;
		end
	end
	always_ff @(posedge clk) begin
		tag_first_s1 <= cmd.issue_first;
		tag_oor_s1   <= ~in_range;
		tag_idx_s1   <= rd_idx;
	end

	// compare against current best, strict so ties keep the earlier one
	assign rd_val = tag_oor_s1 ? '0 : $signed(ram_rdata);
	assign take   = (mode_q == MODE_ARGMAX) ? (best_val_q < rd_val) : (rd_val < best_val_q);

	always_ff @(posedge clk) begin
		if (tag_valid_s1 && (tag_first_s1 || take)) begin
			best_idx_q <= tag_idx_s1;
			best_val_q <= rd_val;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			value_out_q <= best_val_q;
			chosen_q    <= best_idx_q;
		end
	end

	assign result_valid  = result_valid_q;
	assign value_out     = value_out_q;
	assign chosen_action = chosen_q;

	// status back to the controller
	assign sts.clear_last = (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1));
	assign sts.visit_last = ({1'b0, visit_q} == (n_eff - CNT_W'(1)));
	assign sts.is_write   = (mode_q == MODE_WRITE);
	assign sts.is_read    = (mode_q == MODE_READ);
	assign sts.out_free   = ~result_valid_q | ~result_stall;

endmodule

// ===== design/q_value_table_with_argmax_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_value_table_with_argmax_core
// Value table of states by actions (Q16.16) with entry read/write and
// greedy argmax / argmin row scan.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      mode, state_index,
//                                                     action_index, start_action,
//                                                     write_value
//   result    out        result_valid / result_stall  value_out, chosen_action
//   config    in         apb psel/penable/pready      actions_in_use at 0x0
//
// A scan reads one row entry per cycle through the single ram read port, A entries
// with A the effective action count, after the start candidate. After reset a
// clearing pass zeroes the table, one entry per cycle, during which item_stall
// stays high; config writes are taken at any time.
// A stalled result holds in the output register; the sequencer waits in its
// final step only when the previous result is still not taken.
// ----------------------------------------------------------------------------
module q_value_table_with_argmax_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// apb config port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [qvt_pkg::PADDR_W-1:0]      paddr,
	input  logic [qvt_pkg::PDATA_W-1:0]      pwdata,
	output logic [qvt_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	// item channel
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [1:0]                       mode,
	input  logic [qvt_pkg::STATE_W-1:0]      state_index,
	input  logic [qvt_pkg::ACT_W-1:0]        action_index,
	input  logic [qvt_pkg::ACT_W-1:0]        start_action,
	input  logic signed [qvt_pkg::VAL_W-1:0] write_value,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [qvt_pkg::VAL_W-1:0] value_out,
	output logic [qvt_pkg::ACT_W-1:0]        chosen_action
);
	import qvt_pkg::*;

	logic [CNT_W-1:0] actions_q;
	logic             reg_sel;
	logic             cfg_wr;
	ctrl_cmd_t        cmd;
	ctrl_sts_t        sts;

	// config register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == 1'b0);
	assign cfg_wr  = psel & penable & pwrite & pready & reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			actions_q <= ACTIONS_RESET;
		end else if (cfg_wr) begin
			actions_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? PDATA_W'(actions_q) : '0;

	// sequencer
	qvt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	qvt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.actions_in_use (actions_q),
		.mode           (mode),
		.state_index    (state_index),
		.action_index   (action_index),
		.start_action   (start_action),
		.write_value    (write_value),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.value_out      (value_out),
		.chosen_action  (chosen_action)
	);

	// no item taken while the clearing pass runs
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_en |-> item_stall)
		else $error("item accepted during clearing pass");

	// a result only appears after the sequencer finished a transaction
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.finish))
		else $error("result raised without finish");

	// finishing never overwrites a result still waiting
	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!result_valid || !result_stall))
		else $error("result overwritten while stalled");

endmodule

// ===== tb/sv/tb_q_value_table_with_argmax_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q_value_table_with_argmax_core
// Self-checking bench for the value table with greedy action select. A
// clocked driver sends read, write, argmax and argmin transactions from a
// backlog queue. A clocked monitor compares every result against an in-bench
// copy of the table. The action count is reprogrammed over the apb port
// between phases, only while the table is idle.
// ----------------------------------------------------------------------------
module tb_q_value_table_with_argmax_core;

	import qvt_pkg::*;

	localparam int REG_ACTIONS_IN_USE = 0;
	localparam int SETTLE_CYCLES      = 40;
	localparam int LONG_HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT         = 20000;

	typedef struct packed {
		mode_t                    mode;
		logic [STATE_W-1:0]       state;
		logic [ACT_W-1:0]         action;
		logic [ACT_W-1:0]         start;
		logic signed [VAL_W-1:0]  wval;
	} table_op_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  value;
		logic [ACT_W-1:0]         action;
	} table_answer_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// apb port
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// item channel
	logic                     item_valid   = 1'b0;
	logic                     item_stall;
	logic [1:0]               mode         = '0;
	logic [STATE_W-1:0]       state_index  = '0;
	logic [ACT_W-1:0]         action_index = '0;
	logic [ACT_W-1:0]         start_action = '0;
	logic signed [VAL_W-1:0]  write_value  = '0;

	// result channel
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [VAL_W-1:0]  value_out;
	logic [ACT_W-1:0]         chosen_action;

	// bench copy of the table and its action count
	logic signed [VAL_W-1:0]  model_table [STORE_DEPTH];
	logic [CNT_W-1:0]         model_actions = ACTIONS_RESET;

	table_op_t      op_backlog [$];
	table_answer_t  answer_q [$];
	table_op_t      cur_op;

	int unsigned items_accepted = 0;
	int unsigned results_seen   = 0;
	int unsigned scans_sent     = 0;
	int unsigned config_writes  = 0;
	int unsigned err_count      = 0;
	int unsigned send_gap       = 0;
	int unsigned hold_left      = 0;
	int unsigned long_holds     = 0;
	int unsigned idle_cycles    = 0;
	bit          send_idle      = 1'b1;
	bit          recv_idle      = 1'b1;

	q_value_table_with_argmax_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.mode          (mode),
		.state_index   (state_index),
		.action_index  (action_index),
		.start_action  (start_action),
		.write_value   (write_value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.value_out     (value_out),
		.chosen_action (chosen_action)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// effective row width: register clamped to 1..NUM_ACTIONS
	function automatic int unsigned row_width();
		int unsigned n;
		n = model_actions;
		if (n < 1)
			n = 1;
		if (n > NUM_ACTIONS)
			n = NUM_ACTIONS;
		return n;
	endfunction

	// entries past the end of the store read as zero
	function automatic logic signed [VAL_W-1:0] table_peek(input int unsigned addr);
		if (addr >= STORE_DEPTH)
			return '0;
		return model_table[addr];
	endfunction

	// apply one accepted transaction to the bench table, queue its answer
	function automatic void table_model_step(input table_op_t op);
		int unsigned n;
		int unsigned base;
		int unsigned best;
		logic signed [VAL_W-1:0] best_val;
		logic signed [VAL_W-1:0] v;
		bit take;
		table_answer_t ans;
		n    = row_width();
		base = op.state * n;
		case (op.mode)
			MODE_READ: begin
				ans.value  = table_peek(base + op.action);
				ans.action = op.action;
				answer_q.push_back(ans);
			end
			MODE_WRITE: begin
				if (base + op.action < STORE_DEPTH)
					model_table[base + op.action] = op.wval;
			end
			default: begin
				// start candidate out of the row falls back to action 0
				best     = (op.start < n) ? op.start : 0;
				best_val = table_peek(base + best);
				for (int unsigned j = 0; j < n; j++) begin
					v    = table_peek(base + j);
					take = (op.mode == MODE_ARGMAX) ? (v > best_val) : (v < best_val);
					if (take) begin
						best     = j;
						best_val = v;
					end
				end
				ans.value  = best_val;
				ans.action = best[ACT_W-1:0];
				answer_q.push_back(ans);
			end
		endcase
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// small values give ties, extremes hit the sign boundary
	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned r = $urandom_range(99, 0);
		if (r < 35)
			return (32'($urandom_range(4, 0)) - 32'd2) << 16;
		if (r < 50) begin
			case ($urandom_range(3, 0))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'hffff_ffff;
				default: return 32'h0000_0001;
			endcase
		end
		return $urandom;
	endfunction

	function automatic void queue_op(input mode_t m, input int unsigned s,
			input int unsigned a, input int unsigned st, input logic [VAL_W-1:0] v);
		table_op_t op;
		op.mode   = m;
		op.state  = s[STATE_W-1:0];
		op.action = a[ACT_W-1:0];
		op.start  = st[ACT_W-1:0];
		op.wval   = v;
		op_backlog.push_back(op);
	endfunction

	// random part: mostly fill a row then scan it, the rest is noise
	task automatic queue_random_ops(input int unsigned count);
		int unsigned n;
		int unsigned pushed;
		int unsigned len;
		int unsigned s;
		int unsigned hot [8];
		n = row_width();
		foreach (hot[i])
			hot[i] = $urandom_range(255, 0);
		pushed = 0;
		while (pushed < count) begin
			if ($urandom_range(9, 0) < 7) begin
				s   = ($urandom_range(7, 0) == 0) ? $urandom_range(255, 0) : hot[$urandom_range(7, 0)];
				len = $urandom_range(n, 1);
				for (int unsigned k = 0; k < len; k++)
					queue_op(MODE_WRITE, s,
						($urandom_range(9, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(n - 1, 0),
						$urandom_range(15, 0), pick_value());
				queue_op($urandom_range(1, 0) ? MODE_ARGMAX : MODE_ARGMIN, s, $urandom_range(15, 0),
					($urandom_range(4, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(n - 1, 0),
					$urandom);
				pushed += len + 1;
				if ($urandom_range(2, 0) == 0) begin
					queue_op(MODE_READ, s, $urandom_range(15, 0), $urandom_range(15, 0), $urandom);
					pushed++;
				end
			end else begin
				queue_op(mode_t'($urandom_range(3, 0)), $urandom_range(255, 0),
					$urandom_range(15, 0), $urandom_range(15, 0), pick_value());
				pushed++;
			end
		end
	endtask

	// wait until every queued transaction is answered and the core settles
	task automatic wait_idle();
		@(negedge clk);
		while (op_backlog.size() != 0 || item_valid || answer_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// reprogram the action count while idle, then pick the idling style
	task automatic set_actions(input logic [CNT_W-1:0] count, input bit s_idle, input bit r_idle);
		wait_idle();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(REG_ACTIONS_IN_USE * 4);
		pwdata  <= PDATA_W'(count);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		model_actions = count;
		config_writes++;
		send_idle = s_idle;
		recv_idle = r_idle;
	endtask

	// driver: advance the payload only when no transaction is pending on the bus
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				table_model_step(cur_op);
				items_accepted++;
				if (cur_op.mode == MODE_ARGMAX || cur_op.mode == MODE_ARGMIN)
					scans_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					cur_op = op_backlog.pop_front();
					mode         <= cur_op.mode;
					state_index  <= cur_op.state;
					action_index <= cur_op.action;
					start_action <= cur_op.start;
					write_value  <= cur_op.wval;
					item_valid   <= 1'b1;
					send_gap     = send_idle ? pick_gap() : 0;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check results in order, drive the stall pattern
	always @(posedge clk) begin : result_monitor
		table_answer_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (answer_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result value_out=%h chosen_action=%0d",
						$time, value_out, chosen_action);
				end else begin
					want = answer_q.pop_front();
					if (value_out !== want.value) begin
						err_count++;
						$display("%0t: value_out mismatch expected=%h actual=%h",
							$time, want.value, value_out);
					end
					if (chosen_action !== want.action) begin
						err_count++;
						$display("%0t: chosen_action mismatch expected=%0d actual=%0d",
							$time, want.action, chosen_action);
					end
				end
				results_seen++;
			end
			// long hold-offs let the core fill up and stall its input
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if ((long_holds == 0 && results_seen >= 40)
					|| (long_holds == 1 && results_seen >= 200)) begin
				long_holds++;
				hold_left = LONG_HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else if (recv_idle && $urandom_range(99, 0) < 30) begin
				hold_left = pick_gap();
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, answer_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		foreach (model_table[i])
			model_table[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset width of 16: corners, sign extremes, ties
		queue_op(MODE_READ,   0,   0,  0, 32'h0);
		queue_op(MODE_READ,   255, 15, 15, 32'hffff_ffff);
		queue_op(MODE_WRITE,  255, 15, 0, 32'h7fff_ffff);
		queue_op(MODE_WRITE,  255, 0,  0, 32'h8000_0000);
		queue_op(MODE_READ,   255, 15, 0, 32'h0);
		queue_op(MODE_ARGMAX, 255, 0,  0, 32'h0);
		queue_op(MODE_ARGMIN, 255, 0,  15, 32'h0);
		queue_op(MODE_WRITE,  3,   2,  0, 32'h0005_0000);
		queue_op(MODE_WRITE,  3,   9,  0, 32'h0005_0000);
		queue_op(MODE_ARGMAX, 3,   0,  9, 32'h0);
		queue_op(MODE_ARGMAX, 3,   0,  0, 32'h0);
		queue_op(MODE_ARGMIN, 3,   0,  1, 32'h0);
		queue_op(MODE_WRITE,  0,   0,  0, 32'hffff_ffff);
		queue_op(MODE_ARGMIN, 0,   0,  0, 32'h0);

		// narrow rows: column past the row, start past the row
		set_actions(CNT_W'(4), 1'b1, 1'b1);
		queue_op(MODE_WRITE,  1, 6,  0,  32'h0003_0000);
		queue_op(MODE_READ,   2, 2,  0,  32'h0);
		queue_op(MODE_ARGMAX, 2, 0,  7,  32'h0);
		queue_op(MODE_ARGMIN, 1, 0,  9,  32'h0);
		queue_op(MODE_READ,   1, 15, 0,  32'h0);
		queue_random_ops(230);

		// zero acts as one action per row
		set_actions(CNT_W'(0), 1'b1, 1'b0);
		queue_op(MODE_ARGMAX, 5, 0, 3, 32'h0);
		queue_op(MODE_WRITE,  7, 0, 0, 32'hffff_ffff);
		queue_op(MODE_READ,   6, 1, 0, 32'h0);
		queue_op(MODE_ARGMIN, 7, 0, 0, 32'h0);
		queue_random_ops(120);

		// above the table width clamps to the full row, no idling either side
		set_actions(CNT_W'(31), 1'b0, 1'b0);
		queue_random_ops(200);

		set_actions(CNT_W'(1), 1'b0, 1'b1);
		queue_random_ops(120);

		// full rows, with a drain in the middle of the phase
		set_actions(CNT_W'(16), 1'b1, 1'b1);
		queue_random_ops(150);
		wait_idle();
		queue_random_ops(150);

		set_actions(CNT_W'($urandom_range(15, 2)), 1'b1, 1'b1);
		queue_random_ops(150);

		set_actions(CNT_W'(17), 1'b1, 1'b0);
		queue_random_ops(100);

		wait_idle();
		if (answer_q.size() != 0)
			err_count++;
		$display("covered %0d transactions (%0d scans), %0d results checked",
			items_accepted, scans_sent, results_seen);
		$display("over %0d action-count settings, %0d long receiver hold-offs",
			config_writes + 1, long_holds);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
